// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the clock after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent holds in the same clock as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/mugen_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mugen_pkg
// shared widths, generator constants and datapath unit control types
// ----------------------------------------------------------------------------
package mugen_pkg;

	localparam int STREAM_W        = 6;
	localparam int VALUE_W         = 40;
	localparam int SEED_W          = 31;
	localparam int ACC_W           = 64;
	localparam int OPB_W           = 32;
	localparam int NUM_STREAMS_DEF = 64;

	localparam logic [14:0]       LCG_MULT = 15'd16807;
	localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_FOLD = 2'd1,
		OP_CSUB = 2'd2,
		OP_ADD  = 2'd3
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    cin;
	} alu_ctl_t;

endpackage

// ----- sv/mugen_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mugen_req_if
// request channel: command, stream, bounds and seed
// ----------------------------------------------------------------------------
interface mugen_req_if;
	import mugen_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [STREAM_W-1:0]        stream;
	logic signed [VALUE_W-1:0]  low;
	logic signed [VALUE_W-1:0]  high;
	logic [SEED_W-1:0]          seed_value;

	modport source (output valid, command, stream, low, high, seed_value, input ready);
	modport sink (input valid, command, stream, low, high, seed_value, output ready);
endinterface

// ----- sv/mugen_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mugen_rsp_if
// response channel: drawn value and error flag
// ----------------------------------------------------------------------------
interface mugen_rsp_if;
	import mugen_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      error;

	modport source (output valid, value, error, input ready);
	modport sink (input valid, value, error, output ready);
endinterface

// ----- sv/multistream_uniform_int_generator_unit.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// multistream_uniform_int_generator_unit
// park-miller minimal standard generator with one seed per stream and exact
// integer scaling of each draw into [low, high]
// ----------------------------------------------------------------------------
// One request is handled at a time. A seed load or a draw with bad bounds
// (high below low, or a span wider than 2^32) answers in the cycle after it
// is accepted; a good draw runs its steps (seed read, seed times 16807, two
// steps of the modulo, seed times span, three steps of the division by
// 2^31-1, adding low) in turn, all but the seed read on a single shared
// multiply/add unit, save that a span of exactly 2^32 is a plain shift. A new
// request is taken the cycle after the response transaction completes.
// Streams at or beyond NUM_STREAMS use stream 0, and a stream must be loaded
// before it is drawn; the seed memory is not cleared by reset.
// ----------------------------------------------------------------------------
module multistream_uniform_int_generator_unit #(
	parameter int NUM_STREAMS = mugen_pkg::NUM_STREAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mugen_req_if.sink   req,
	mugen_rsp_if.source rsp
);
	import mugen_pkg::*;

	localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_READ = 10'b00_0000_0010,
		ST_MOD1 = 10'b00_0000_0100,
		ST_MOD2 = 10'b00_0000_1000,
		ST_MULS = 10'b00_0001_0000,
		ST_DIV1 = 10'b00_0010_0000,
		ST_DIV2 = 10'b00_0100_0000,
		ST_DIV3 = 10'b00_1000_0000,
		ST_FIN  = 10'b01_0000_0000,
		ST_RESP = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [AW-1:0]             idx_q;
	logic signed [VALUE_W-1:0] lo_q;
	logic [OPB_W:0]            span_q;
	logic [ACC_W-1:0]          acc_q;
	logic [SEED_W-1:0]         seed_q;
	logic [OPB_W-1:0]          hq_q;
	logic [2:0]                h2_q;
	logic [VALUE_W-1:0]        value_q;
	logic                      error_q;

	logic                      accept;
	logic [AW-1:0]             idx;
	logic signed [VALUE_W+1:0] diff;
	logic                      full_range;
	logic                      bad_bounds;

	alu_ctl_t         ctl;
	logic [ACC_W-1:0] alu_a;
	logic [OPB_W-1:0] alu_b;
	logic [ACC_W-1:0] alu_y;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [SEED_W-1:0] mem_wdata;
	logic [SEED_W-1:0] mem_rdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = (state_q == ST_RESP);
	assign rsp.value = value_q;
	assign rsp.error = error_q;

	// out-of-range streams fall back to stream 0
	assign idx = (32'(req.stream) < NUM_STREAMS) ? AW'(req.stream) : '0;

	assign diff       = (VALUE_W+2)'(req.high) - (VALUE_W+2)'(req.low) + 42'sd1;
	assign full_range = (req.low == '0) && (req.high == VALUE_W'(LCG_MOD));
	assign bad_bounds = (req.high < req.low)
		|| (!full_range && (diff > 42'sd4294967296));

	assign mem_we    = (accept && req.command) || (state_q == ST_MOD2);
	assign mem_waddr = (state_q == ST_MOD2) ? idx_q : idx;
	assign mem_wdata = (state_q == ST_MOD2) ? alu_y[SEED_W-1:0] : req.seed_value;

	mugen_seed_ram #(
		.DEPTH (NUM_STREAMS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept && !req.command),
		.raddr (idx),
		.rdata (mem_rdata)
	);

	always_comb begin
		ctl.op  = OP_ADD;
		ctl.cin = 1'b0;
		alu_a   = acc_q;
		alu_b   = '0;
		unique case (state_q)
			ST_READ: begin
				ctl.op = OP_MUL;
				alu_a  = {{(ACC_W-SEED_W){1'b0}}, mem_rdata};
				alu_b  = OPB_W'(LCG_MULT);
			end
			ST_MOD1: begin
				ctl.op = OP_FOLD;
			end
			ST_MOD2: begin
				ctl.op = OP_CSUB;
			end
			ST_MULS: begin
				ctl.op = OP_MUL;
				alu_a  = {{(ACC_W-SEED_W){1'b0}}, seed_q};
				alu_b  = span_q[OPB_W-1:0];
			end
			ST_DIV1, ST_DIV2: begin
				ctl.op = OP_FOLD;
			end
			ST_DIV3: begin
				ctl.cin = (acc_q[33:0] >= 34'(LCG_MOD));
				alu_a   = {{(ACC_W-OPB_W){1'b0}}, hq_q};
				alu_b   = OPB_W'(h2_q);
			end
			ST_FIN: begin
				alu_a = {{(ACC_W-VALUE_W){lo_q[VALUE_W-1]}}, lo_q};
				alu_b = acc_q[OPB_W-1:0];
			end
			default: begin
				ctl.op = OP_ADD;
			end
		endcase
	end

	mugen_alu u_alu (
		.ctl (ctl),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.command || bad_bounds) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_MOD1;
				ST_MOD1: state_q <= ST_MOD2;
				ST_MOD2: state_q <= ST_MULS;
				ST_MULS: state_q <= ST_DIV1;
				ST_DIV1: state_q <= ST_DIV2;
				ST_DIV2: state_q <= ST_DIV3;
				ST_DIV3: state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_RESP;
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q   <= idx;
					lo_q    <= req.low;
					span_q  <= full_range ? (OPB_W+1)'(LCG_MOD) : diff[OPB_W:0];
					value_q <= '0;
					error_q <= !req.command && bad_bounds;
				end
			end
			ST_READ, ST_MOD1, ST_DIV3: begin
				acc_q <= alu_y;
			end
			ST_MOD2: begin
				seed_q <= alu_y[SEED_W-1:0];
			end
			ST_MULS: begin
				// span of exactly 2^32 is a plain shift
				acc_q <= span_q[OPB_W] ? {1'b0, seed_q, {OPB_W{1'b0}}} : alu_y;
			end
			ST_DIV1: begin
				hq_q  <= acc_q[62:31];
				acc_q <= alu_y;
			end
			ST_DIV2: begin
				h2_q  <= acc_q[33:31];
				acc_q <= alu_y;
			end
			ST_FIN: begin
				value_q <= alu_y[VALUE_W-1:0];
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_no_overlap, !(req.ready && rsp.valid), "request taken while response pending")
	`ASSERT_IMPLY(a_err_zero, rsp.valid && rsp.error, rsp.value == '0, "error response with nonzero value")
	`ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "second request accepted back to back")
	`ASSERT_IMPLY(a_seed_wr_in_range, mem_we, 32'(mem_waddr) < NUM_STREAMS, "seed write outside stream range")
endmodule

// ----- sv/mugen_seed_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mugen_seed_ram
// per-stream seed memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module mugen_seed_ram #(
	parameter int  DEPTH = mugen_pkg::NUM_STREAMS_DEF,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mugen_pkg::SEED_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [mugen_pkg::SEED_W-1:0] rdata
);
	import mugen_pkg::*;

	logic [SEED_W-1:0] mem [DEPTH];
	logic [SEED_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sv/mugen_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mugen_alu
// shared datapath unit: 32x32 multiply, mersenne fold, conditional
// subtract of the modulus, add with carry in
// ----------------------------------------------------------------------------
module mugen_alu (
	input  mugen_pkg::alu_ctl_t         ctl,
	input  logic [mugen_pkg::ACC_W-1:0] a,
	input  logic [mugen_pkg::OPB_W-1:0] b,
	output logic [mugen_pkg::ACC_W-1:0] y
);
	import mugen_pkg::*;

	logic [ACC_W-1:0] prod;
	logic [ACC_W-1:0] fold;
	logic [ACC_W-1:0] csub;
	logic [ACC_W-1:0] sum;
	logic [ACC_W-1:0] modw;

	assign modw = ACC_W'(LCG_MOD);
	assign prod = a[OPB_W-1:0] * b;
	// x mod (2^31-1) congruent to low 31 bits plus the rest
	assign fold = {{(ACC_W-SEED_W){1'b0}}, a[SEED_W-1:0]}
		+ {{SEED_W{1'b0}}, a[ACC_W-1:SEED_W]};
	assign csub = (a >= modw) ? (a - modw) : a;
	assign sum  = a + {{(ACC_W-OPB_W){1'b0}}, b} + {{(ACC_W-1){1'b0}}, ctl.cin};

	always_comb begin
		unique case (ctl.op)
			OP_MUL:  y = prod;
			OP_FOLD: y = fold;
			OP_CSUB: y = csub;
			OP_ADD:  y = sum;
			default: y = sum;
		endcase
	end
endmodule
